@@ rtl/bb3_pkg.sv @@
// Shared types and constants for the 3x3 RGB box blur.
// Used by every module of the block; no dependencies.
package bb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int SIZE_W = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int AREA_W = CNT_W + 1;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int SUM_W  = $clog2(9 * (2 ** CH_W - 1) + 1);

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [SIZE_W-1:0] size_t;

	// red sits in the lowest bits, as on the stream buses
	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pix_t;

	// number of window taps inside the frame
	typedef logic [3:0] taps_t;
	localparam taps_t TAPS_ONE   = 4'd1;
	localparam taps_t TAPS_TWO   = 4'd2;
	localparam taps_t TAPS_THREE = 4'd3;
	localparam taps_t TAPS_FOUR  = 4'd4;
	localparam taps_t TAPS_SIX   = 4'd6;
	localparam taps_t TAPS_NINE  = 4'd9;

	typedef struct packed {
		logic capture;
		logic upd;
		logic sum;
		logic mul;
		logic emit;
		logic div_start;
	} bb3_cmd_t;

	typedef struct packed {
		logic has_res;
		logic out_free;
		logic div_done;
	} bb3_sts_t;

endpackage

@@ rtl/bb3_div.sv @@
// Restoring divider, one quotient bit per cycle: result count by line width.
// Depends on bb3_pkg.
module bb3_div
	import bb3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  size_t            divisor,
	output logic             done,
	output logic [CNT_W-1:0] quot,
	output logic [COL_W-1:0] rem
);

	localparam int STEP_W = $clog2(CNT_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]  quot_q;
	logic [SIZE_W:0]   shifted;
	logic [SIZE_W:0]   diff;
	logic              ge;

	assign shifted = {rem_q, quot_q[CNT_W-1]};
	assign ge      = shifted >= (SIZE_W + 1)'(divisor);
	assign diff    = shifted - (SIZE_W + 1)'(divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CNT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
			quot_q <= {quot_q[CNT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q[COL_W-1:0];

endmodule

@@ rtl/bb3_mean.sv @@
// Rounded mean of one channel: (2*sum+n)/(2*n) for n in 1,2,3,4,6,9.
// Divisors 3, 6 and 9 use a reciprocal multiply; depends on bb3_pkg.
module bb3_mean
	import bb3_pkg::*;
(
	input  logic [SUM_W-1:0] sum,
	input  taps_t            taps,
	output chan_t            mean
);

	localparam int NUM_W   = SUM_W + 1;
	localparam int RCP_W   = 18;
	localparam int RCP_SH  = 19;
	localparam logic [RCP_W-1:0] RECIP_THREE = 18'd174763;
	localparam logic [RCP_W-1:0] RECIP_NINE  = 18'd58255;

	logic [NUM_W-1:0]       sum_p1;
	logic [NUM_W-1:0]       sum_p2;
	logic [NUM_W-1:0]       sum_p3;
	logic [NUM_W-1:0]       sum_p4;
	logic [NUM_W-1:0]       num;
	logic [RCP_W-1:0]       recip;
	logic [NUM_W+RCP_W-1:0] prod;
	chan_t                  byp;
	logic                   use_mul;

	assign sum_p1 = NUM_W'(sum) + NUM_W'(1);
	assign sum_p2 = NUM_W'(sum) + NUM_W'(2);
	assign sum_p3 = NUM_W'(sum) + NUM_W'(3);
	assign sum_p4 = NUM_W'(sum) + NUM_W'(4);

	always_comb begin
		num     = '0;
		recip   = '0;
		byp     = '0;
		use_mul = 1'b0;
		unique case (taps)
			TAPS_ONE: begin
				byp = sum[CH_W-1:0];
			end
			TAPS_TWO: begin
				byp = sum_p1[CH_W:1];
			end
			TAPS_FOUR: begin
				byp = sum_p2[CH_W+1:2];
			end
			TAPS_THREE: begin
				num     = sum_p1;
				recip   = RECIP_THREE;
				use_mul = 1'b1;
			end
			TAPS_SIX: begin
				num     = {1'b0, sum_p3[NUM_W-1:1]};
				recip   = RECIP_THREE;
				use_mul = 1'b1;
			end
			TAPS_NINE: begin
				num     = sum_p4;
				recip   = RECIP_NINE;
				use_mul = 1'b1;
			end
			default: begin
				byp = '0;
			end
		endcase
	end

	assign prod = (NUM_W + RCP_W)'(num) * (NUM_W + RCP_W)'(recip);
	assign mean = use_mul ? prod[RCP_SH +: CH_W] : byp;

endmodule

@@ rtl/bb3_dpath.sv @@
// Datapath: line stores, 3x3 window, position counters, sums, means, output register.
// Depends on bb3_pkg, bb3_div and bb3_mean.
module bb3_dpath
	import bb3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  bb3_cmd_t cmd,
	output bb3_sts_t sts,
	input  pix_t     in_pix,
	input  logic     in_pad,
	input  size_t    width,
	input  size_t    height,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_t     out_pix,
	output logic     out_last
);

	localparam logic [1:0] ROW_SAT = 2'd2;

	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];

	pix_t             win_q [3][3];
	pix_t             rd_top_q;
	pix_t             rd_mid_q;
	pix_t             pix_q;
	logic [COL_W-1:0] col_q;
	logic             has_res_q;

	logic [COL_W-1:0] in_col_q;
	logic [1:0]       in_row_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [CNT_W-1:0] r_q;
	logic [COL_W-1:0] c_q;
	logic [AREA_W-1:0] wh_q;

	logic [SUM_W-1:0] sum_q [3];
	taps_t            taps_q;
	chan_t            mean_w [3];
	chan_t            mean_q [3];

	logic             out_valid_q;
	pix_t             out_pix_q;
	logic             out_last_q;

	logic [2*SIZE_W-1:0] area_full;
	logic [SIZE_W-1:0]   col_p1;
	logic                started;
	logic [CNT_W:0]      r_p1;
	logic [SIZE_W-1:0]   c_p1;
	logic [AREA_W-1:0]   cnt_p1;
	logic                area_hit;
	logic [2:0]          row_en;
	logic [2:0]          col_en;
	logic [1:0]          n_rows;
	logic [1:0]          n_cols;
	logic [SUM_W-1:0]    sum_w [3];
	logic                div_done;
	logic [CNT_W-1:0]    div_quot;
	logic [COL_W-1:0]    div_rem;

	assign area_full = (2 * SIZE_W)'(width) * (2 * SIZE_W)'(height);
	assign col_p1    = SIZE_W'(in_col_q) + SIZE_W'(1);
	assign started   = (in_row_q == 2'd0 && SIZE_W'(in_col_q) > width) ||
		(in_row_q == 2'd1 && in_col_q != '0) || (in_row_q == ROW_SAT);
	assign r_p1      = (CNT_W + 1)'(r_q) + (CNT_W + 1)'(1);
	assign c_p1      = SIZE_W'(c_q) + SIZE_W'(1);
	assign cnt_p1    = AREA_W'(out_cnt_q) + AREA_W'(1);
	assign area_hit  = cnt_p1 >= wh_q;

	assign row_en[0] = r_q != '0;
	assign row_en[1] = 1'b1;
	assign row_en[2] = r_p1 < (CNT_W + 1)'(height);
	assign col_en[0] = c_q != '0;
	assign col_en[1] = 1'b1;
	assign col_en[2] = c_p1 < width;
	assign n_rows    = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
	assign n_cols    = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_w[k] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (row_en[i] && col_en[j]) begin
						sum_w[k] = sum_w[k] + SUM_W'(win_q[i][j][k*CH_W +: CH_W]);
					end
				end
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_mean
		bb3_mean u_mean (
			.sum  (sum_q[k]),
			.taps (taps_q),
			.mean (mean_w[k])
		);
	end

	bb3_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (out_cnt_q),
		.divisor  (width),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_top_q <= upper_mem[in_col_q];
			rd_mid_q <= middle_mem[in_col_q];
		end
		if (cmd.upd) begin
			upper_mem[col_q]  <= rd_mid_q;
			middle_mem[col_q] <= pix_q;
		end
	end

	always_ff @(posedge clk) begin
		wh_q <= area_full[AREA_W-1:0];
		if (cmd.capture) begin
			pix_q     <= in_pad ? '0 : in_pix;
			col_q     <= in_col_q;
			has_res_q <= started;
		end
		if (cmd.sum) begin
			for (int k = 0; k < 3; k++) begin
				sum_q[k] <= sum_w[k];
			end
			taps_q <= taps_t'(n_rows) * taps_t'(n_cols);
		end
		if (cmd.mul) begin
			for (int k = 0; k < 3; k++) begin
				mean_q[k] <= mean_w[k];
			end
		end
		if (cmd.emit) begin
			out_pix_q  <= '{blue: mean_q[2], green: mean_q[1], red: mean_q[0]};
			out_last_q <= area_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cmd.upd) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_top_q;
			win_q[1][2] <= rd_mid_q;
			win_q[2][2] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_cnt_q   <= '0;
			r_q         <= '0;
			c_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				if (col_p1 >= width) begin
					in_col_q <= '0;
					if (in_row_q != ROW_SAT) begin
						in_row_q <= in_row_q + 1'b1;
					end
				end else begin
					in_col_q <= col_p1[COL_W-1:0];
				end
			end
			if (div_done) begin
				r_q <= div_quot;
				c_q <= div_rem;
			end
			if (cmd.emit) begin
				if (area_hit) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_cnt_q <= '0;
					r_q       <= '0;
					c_q       <= '0;
				end else begin
					out_cnt_q <= cnt_p1[CNT_W-1:0];
					if (c_p1 >= width) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_p1[COL_W-1:0];
					end
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.has_res  = has_res_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.div_done = div_done;

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;

endmodule

@@ rtl/bb3_ctrl.sv @@
// Controller: steps an item through capture, window update and, with a result, sum,
// mean, output; runs the position divider after a size write. Depends on bb3_pkg.
module bb3_ctrl
	import bb3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     cfg_wr,
	input  bb3_sts_t sts,
	output bb3_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       pend_q;
	logic       pend_d;

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q || cfg_wr;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_wr || pend_q) begin
					cmd.div_start = 1'b1;
					pend_d        = 1'b0;
					state_d       = ST_DIV;
				end else begin
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.has_res ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (cfg_wr) begin
					cmd.div_start = 1'b1;
					pend_d        = 1'b0;
				end else if (sts.div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

endmodule

@@ rtl/box_blur_3x3_rgb.sv @@
// 3x3 box blur of an RGB stream. The result for pixel k leaves on item k+width+1.
// An item is accepted, then passes the update, sum, mean and output states to reach the
// output register when it yields a result, and only the update state when it does not;
// no new item is taken meanwhile. A size write holds off input while a bit-serial
// divider re-derives row and column of the result counter. Reset clears control and
// sets 640x480; line stores are not cleared. Depends on bb3_pkg, bb3_ctrl, bb3_dpath.
module box_blur_3x3_rgb
	import bb3_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_red, in_green, in_blue
	input  logic        s_axis_tuser,  // pad_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_red, out_green, out_blue
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic  REG_WIDTH  = 1'b0;
	localparam logic  REG_HEIGHT = 1'b1;
	localparam size_t RST_WIDTH  = SIZE_W'(640);
	localparam size_t RST_HEIGHT = SIZE_W'(480);

	size_t    width_q;
	size_t    height_q;
	size_t    width_eff;
	size_t    height_eff;
	logic     wr_en;
	bb3_cmd_t cmd;
	bb3_sts_t sts;
	pix_t     out_pix;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default:    width_q  <= width_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_comb begin
		if (width_q == '0) begin
			width_eff = SIZE_W'(1);
		end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
			width_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			width_eff = width_q;
		end
		if (height_q == '0) begin
			height_eff = SIZE_W'(1);
		end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
			height_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			height_eff = height_q;
		end
	end

	bb3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cfg_wr   (wr_en),
		.sts      (sts),
		.cmd      (cmd)
	);

	bb3_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_pix    (pix_t'(s_axis_tdata)),
		.in_pad    (s_axis_tuser),
		.width     (width_eff),
		.height    (height_eff),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_pix;

endmodule
